// File: sv/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// Linear blend skinning package
// Shared types, constants and rounding helpers for the skinning core.
// ----------------------------------------------------------------------------
package lbvs_pkg;

   localparam int BoneCountDefault     = 64;
   localparam int MaxInfluencesDefault = 4;
   localparam int PackedSlots          = 4;
   localparam int PalElems             = 12;

   // Item opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SKIN  = 1'b1;

   typedef struct packed {
      logic               op;
      logic [5:0]         bone_index;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [23:0]        influence_bones;
      logic [63:0]        influence_weights;
      logic [2:0]         influence_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] skinned_x;
      logic signed [31:0] skinned_y;
      logic signed [31:0] skinned_z;
      logic               saturated;
   } rsp_type;

   // Address bits needed to pick one palette entry; at least one.
   function automatic int bone_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Round a signed 64-bit Q32.32 product half away from zero to Q32.16 (48 bits).
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic [63:0] mag;
      logic [47:0] r;
      mag = p[63] ? (64'd0 - p) : p;
      r   = 48'((mag + 64'h8000) >> 16);
      return p[63] ? (48'sd0 - $signed(r)) : $signed(r);
   endfunction

   // Round a signed term times Q1.15 weight half away from zero, dropping 15 bits.
   function automatic logic signed [55:0] round_w(input logic signed [66:0] p);
      logic [66:0] mag;
      logic [55:0] r;
      mag = p[66] ? (67'd0 - p) : p;
      r   = 56'((mag + 67'h4000) >> 15);
      return p[66] ? (56'sd0 - $signed(r)) : $signed(r);
   endfunction

endpackage

// File: sv/lbvs_slot.sv
// ----------------------------------------------------------------------------
// Skinning slot
// Holds one copy of the palette and transforms the vertex by one influence.
// Stage 1 reads the entry, stage 2 forms the nine products, stage 3 sums the
// axis terms, stage 4 applies the weight. Every stage moves only while
// advance is high.
// ----------------------------------------------------------------------------
module lbvs_slot #(
   parameter int BoneCount = lbvs_pkg::BoneCountDefault
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic                     wr_en,
   input  logic [lbvs_pkg::bone_bits(BoneCount)-1:0] wr_bone,
   input  logic [3:0]               wr_elem,
   input  logic [31:0]              wr_data,
   input  logic [lbvs_pkg::bone_bits(BoneCount)-1:0] rd_bone,
   input  logic                     rd_use,
   input  logic signed [31:0]       pos_x,
   input  logic signed [31:0]       pos_y,
   input  logic signed [31:0]       pos_z,
   input  logic [15:0]              weight,
   output logic signed [55:0]       term_x,
   output logic signed [55:0]       term_y,
   output logic signed [55:0]       term_z
);
   logic [31:0] ent [lbvs_pkg::PalElems];
   logic        use1_ff, use2_ff, use3_ff;
   logic signed [31:0] px1_ff, py1_ff, pz1_ff;
   logic [15:0] w1_ff, w2_ff, w3_ff;
   logic signed [47:0] prod_ff [9];
   logic signed [31:0] tr_ff [3];
   logic signed [50:0] t_ff [3];
   logic signed [55:0] o_ff [3];

   // Each element has its own bank so that a whole entry reads at once.
   for (genvar e = 0; e < lbvs_pkg::PalElems; e++) begin : g_bank
      logic [31:0] bank_ff [BoneCount];
      logic [31:0] ent_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_elem == 4'(e))) begin
            bank_ff[wr_bone] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ent_ff <= bank_ff[rd_bone];
         end
      end

      assign ent[e] = ent_ff;
   end

   // Pipeline of products, sums and weighting.
   always_ff @(posedge clock) begin
      if (advance) begin
         use1_ff <= rd_use;
         px1_ff <= pos_x;
         py1_ff <= pos_y;
         pz1_ff <= pos_z;
         w1_ff <= weight;
         for (int a = 0; a < 3; a++) begin
            prod_ff[a*3+0] <= lbvs_pkg::round_q16(64'($signed(ent[a*4+0])) * 64'(px1_ff));
            prod_ff[a*3+1] <= lbvs_pkg::round_q16(64'($signed(ent[a*4+1])) * 64'(py1_ff));
            prod_ff[a*3+2] <= lbvs_pkg::round_q16(64'($signed(ent[a*4+2])) * 64'(pz1_ff));
            tr_ff[a]       <= $signed(ent[a*4+3]);
            t_ff[a] <= 51'(prod_ff[a*3]) + 51'(prod_ff[a*3+1]) + 51'(prod_ff[a*3+2])
                       + 51'(tr_ff[a]);
            o_ff[a] <= use3_ff ?
                       lbvs_pkg::round_w(67'(t_ff[a]) * 67'($signed({1'b0, w3_ff})))
                       : 56'sd0;
         end
         use2_ff <= use1_ff;
         use3_ff <= use2_ff;
         w2_ff <= w1_ff;
         w3_ff <= w2_ff;
      end
   end

   assign term_x = o_ff[0];
   assign term_y = o_ff[1];
   assign term_z = o_ff[2];
endmodule

// File: sv/linear_blend_vertex_skinning_core.sv
// ----------------------------------------------------------------------------
// Linear blend vertex skinning core
// Streams vertices through four parallel influence slots and blends them.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_ready | lbvs_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready | lbvs_pkg::rsp_type
//
// One transaction enters per cycle while the output is not stalled; a skin result
// passes the four slot stages, the blend sum register and the output register.
// Every palette element has its own bank per slot, so a whole entry reads at once.
// Reset clears the valid bits only; the palette is undefined until written.
// While a result waits, req_ready follows rsp_ready and a stall freezes every
// stage, so nothing is lost or repeated.
module linear_blend_vertex_skinning_core #(
   parameter int BoneCount     = lbvs_pkg::BoneCountDefault,
   parameter int MaxInfluences = lbvs_pkg::MaxInfluencesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbvs_pkg::rsp_type rsp_data
);
   localparam int Lim   = (MaxInfluences < lbvs_pkg::PackedSlots) ?
                          MaxInfluences : lbvs_pkg::PackedSlots;
   localparam int BW    = lbvs_pkg::bone_bits(BoneCount);
   localparam int Stages = 5;

   logic advance;
   logic [Stages-1:0] vld_ff;
   logic wr_en;
   logic [2:0] cnt;
   logic signed [55:0] tx [lbvs_pkg::PackedSlots];
   logic signed [55:0] ty [lbvs_pkg::PackedSlots];
   logic signed [55:0] tz [lbvs_pkg::PackedSlots];
   logic signed [57:0] sum_ff [3];
   lbvs_pkg::rsp_type out_in;
   logic out_vld_ff;
   lbvs_pkg::rsp_type out_ff;

   // Pipeline advances whenever the output register can take data.
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = advance && !reset;

   // Palette write decode; out of range writes are dropped.
   assign wr_en = req_valid && req_ready && (req_data.op == lbvs_pkg::OP_WRITE)
                  && (32'(req_data.bone_index) < 32'(BoneCount))
                  && (req_data.element_index < 4'(lbvs_pkg::PalElems));
   assign cnt = (req_data.influence_count > 3'(Lim)) ? 3'(Lim)
                                                     : req_data.influence_count;

   // One slot unit per packed influence.
   for (genvar s = 0; s < lbvs_pkg::PackedSlots; s++) begin : g_slot
      logic [5:0] bone;
      logic       use_s;
      assign bone  = req_data.influence_bones[6*s +: 6];
      assign use_s = (3'(s) < cnt) && (32'(bone) < 32'(BoneCount));
      lbvs_slot #(.BoneCount(BoneCount)) u_slot (
         .clock   (clock),
         .advance (advance),
         .wr_en   (wr_en),
         .wr_bone (BW'(req_data.bone_index)),
         .wr_elem (req_data.element_index),
         .wr_data (req_data.element_value),
         .rd_bone (BW'(bone)),
         .rd_use  (use_s),
         .pos_x   (req_data.pos_x),
         .pos_y   (req_data.pos_y),
         .pos_z   (req_data.pos_z),
         .weight  (req_data.influence_weights[16*s +: 16]),
         .term_x  (tx[s]),
         .term_y  (ty[s]),
         .term_z  (tz[s])
      );
   end

   // Valid bits follow skin transactions down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Stages-2:0],
                    req_valid && req_ready && (req_data.op == lbvs_pkg::OP_SKIN)};
      end
   end

   // Blend the slot terms.
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff[0] <= 58'(tx[0]) + 58'(tx[1]) + 58'(tx[2]) + 58'(tx[3]);
         sum_ff[1] <= 58'(ty[0]) + 58'(ty[1]) + 58'(ty[2]) + 58'(ty[3]);
         sum_ff[2] <= 58'(tz[0]) + 58'(tz[1]) + 58'(tz[2]) + 58'(tz[3]);
      end
   end

   // Saturate to 32 bits.
   always_comb begin
      logic [2:0] sat;
      logic signed [31:0] v [3];
      for (int a = 0; a < 3; a++) begin
         if (sum_ff[a] > 58'sh7FFFFFFF) begin
            v[a] = 32'sh7FFFFFFF;
            sat[a] = 1'b1;
         end else if (sum_ff[a] < -58'sh80000000) begin
            v[a] = 32'sh80000000;
            sat[a] = 1'b1;
         end else begin
            v[a] = sum_ff[a][31:0];
            sat[a] = 1'b0;
         end
      end
      out_in.skinned_x = v[0];
      out_in.skinned_y = v[1];
      out_in.skinned_z = v[2];
      out_in.saturated = |sat;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // A stalled result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // Write transactions never produce a result.
   a_nowr: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.op == lbvs_pkg::OP_WRITE) |=> !vld_ff[0])
      else $error("write transaction entered the result pipeline");

   // A stall freezes the pipeline valid bits.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
`endif
endmodule
